/* src/snfr_pkg.sv */
// ----------------------------------------------------------------------------
// snfr_pkg
// Shared types, constants and a helper function of the serial-number frame
// receiver.
// ----------------------------------------------------------------------------
package snfr_pkg;

    localparam int MAX_FRAME    = 40;
    localparam int SERIAL_BYTES = 15;

    localparam int CNT_W  = 6;
    localparam int SER_AW = (SERIAL_BYTES > 1) ? $clog2(SERIAL_BYTES) : 1;
    localparam int IDX_W  = (SER_AW > 3) ? SER_AW : 3;

    localparam logic [7:0]  HDR0          = 8'hFA;
    localparam logic [7:0]  HDR1          = 8'hCE;
    localparam logic [15:0] SN_CMD        = 16'h2001;
    localparam logic [7:0]  REPLY_LEN_FLD = 8'h04;
    localparam logic [7:0]  LEN_MIN       = 8'd3;
    localparam logic [7:0]  LEN_MAX       = 8'(MAX_FRAME - 3);
    localparam logic [7:0]  LEN_GOOD      = 8'(SERIAL_BYTES + 3);
    localparam logic [CNT_W-1:0] POS_CMD_HI = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_CMD_LO = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_SER0   = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_SUM    = CNT_W'(SERIAL_BYTES + 5);
    localparam logic [2:0]  REPLY_LAST    = 3'd6;

    localparam logic [7:0] RES_OK       = 8'h00;
    localparam logic [7:0] RES_LENGTH   = 8'h01;
    localparam logic [7:0] RES_PARAM    = 8'h02;
    localparam logic [7:0] RES_CHECKSUM = 8'h03;
    localparam logic [7:0] RES_WRITE    = 8'h04;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_SERIAL = 1'b1;
    localparam logic FUNC_BYTE   = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REPLY  = 4'b0010,
        S_SER_RD = 4'b0100,
        S_SER_WR = 4'b1000
    } t_state;

    // One byte of the reply frame FA CE 04 cmd_hi cmd_lo result sum.
    function automatic logic [7:0] reply_byte(input logic [2:0] idx,
                                              input logic [15:0] cmd,
                                              input logic [7:0] res);
        logic [7:0] sum;
        logic [7:0] b;
        begin
            sum = HDR0 + HDR1 + REPLY_LEN_FLD + cmd[15:8] + cmd[7:0] + res;
            case (idx)
                3'd0:    b = HDR0;
                3'd1:    b = HDR1;
                3'd2:    b = REPLY_LEN_FLD;
                3'd3:    b = cmd[15:8];
                3'd4:    b = cmd[7:0];
                3'd5:    b = res;
                default: b = sum;
            endcase
            return b;
        end
    endfunction

endpackage

/* src/serial_number_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// serial_number_frame_receiver_top
// Frame receiver for serial-number programming: header hunt, frame checks,
// serial byte buffer and reply generation.
// ----------------------------------------------------------------------------
// Received bytes enter one word per cycle while the block is idle. Each byte
// of a frame (FA CE L, then L more bytes) is handled in the cycle it is
// taken; the serial bytes are written into a small synchronous buffer memory
// as they arrive. When the last byte of a frame fails a check, or when a
// storage outcome word arrives while one is awaited, the block sends a
// 7-word reply, one word per cycle unless the output stalls, and takes no
// input meanwhile. A good frame instead sends its 15 serial bytes to
// storage; each byte is first read from the buffer memory in S_SER_RD and
// then loaded into the output register in S_SER_WR, and the input is held
// off for the whole run. Input is taken only while idle and the buffer read
// result is used only during a serial run, so a buffer write never meets a
// buffer read whose result is used. Input may resume while the last word of
// a run still waits on a stalled output; every output word carries the
// success flag that held when it was loaded. A stalled output only lengthens
// emission. The buffer needs no clearing after reset: every entry is written
// by a frame before a good frame reads it.
module serial_number_frame_receiver_top
    import snfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] rx_byte, [8] store_ok, [15:9] zero
    input  logic        i_s_tuser,   // [0] func

    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] data, [8] serial_ok, [15:9] zero
    output logic        o_m_tlast,
    output logic        o_m_tuser    // [0] kind
);

    // Frame and control state.
    t_state           r_state,      n_state;
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [CNT_W-1:0] r_frame_total, n_frame_total;
    logic [7:0]       r_length,     n_length;
    logic [15:0]      r_cmd,        n_cmd;
    logic [7:0]       r_sum,        n_sum;
    logic             r_await,      n_await;
    logic             r_ok_flag,    n_ok_flag;
    logic [7:0]       r_result,     n_result;
    logic [IDX_W-1:0] r_idx,        n_idx;

    // Output register.
    logic             r_m_tvalid,   n_m_tvalid;
    logic [7:0]       r_m_data,     n_m_data;
    logic             r_m_last,     n_m_last;
    logic             r_m_kind,     n_m_kind;
    logic             r_m_ok,       n_m_ok;

    // Serial byte buffer.
    logic [7:0]        r_mem [SERIAL_BYTES];
    logic [7:0]        r_mem_q;
    logic              w_wr_en;
    logic [SER_AW-1:0] w_wr_addr;

    logic             w_accept;
    logic             w_func;
    logic [7:0]       w_byte;
    logic             w_store_ok;
    logic             w_slot_free;
    logic [CNT_W-1:0] w_pos_next;

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_func      = i_s_tuser;
    assign w_byte      = i_s_tdata[7:0];
    assign w_store_ok  = i_s_tdata[8];
    assign w_slot_free = !r_m_tvalid || i_m_tready;
    assign w_pos_next  = r_byte_count + CNT_W'(1);
    assign w_wr_addr   = SER_AW'(r_byte_count - POS_SER0);

    always_comb begin
        n_state       = r_state;
        n_byte_count  = r_byte_count;
        n_frame_total = r_frame_total;
        n_length      = r_length;
        n_cmd         = r_cmd;
        n_sum         = r_sum;
        n_await       = r_await;
        n_ok_flag     = r_ok_flag;
        n_result      = r_result;
        n_idx         = r_idx;
        n_m_tvalid    = r_m_tvalid && !i_m_tready;
        n_m_data      = r_m_data;
        n_m_last      = r_m_last;
        n_m_kind      = r_m_kind;
        n_m_ok        = r_m_ok;
        w_wr_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_func == FUNC_REPORT) begin
                    // A storage outcome counts only while one is awaited.
                    if (r_await) begin
                        n_await   = 1'b0;
                        n_ok_flag = w_store_ok;
                        n_cmd     = SN_CMD;
                        n_result  = w_store_ok ? RES_OK : RES_WRITE;
                        n_idx     = '0;
                        n_state   = S_REPLY;
                    end
                end else if (w_accept) begin
                    if (r_byte_count == '0) begin
                        if (w_byte == HDR0) begin
                            n_sum        = w_byte;
                            n_byte_count = CNT_W'(1);
                        end
                    end else if (r_byte_count == CNT_W'(1)) begin
                        // A wrong second header byte is not retried as FA.
                        if (w_byte == HDR1) begin
                            n_sum        = r_sum + w_byte;
                            n_byte_count = CNT_W'(2);
                        end else begin
                            n_byte_count  = '0;
                            n_frame_total = '0;
                        end
                    end else if (r_byte_count == CNT_W'(2)) begin
                        n_length = w_byte;
                        if (w_byte < LEN_MIN || w_byte > LEN_MAX) begin
                            n_byte_count  = '0;
                            n_frame_total = '0;
                        end else begin
                            n_frame_total = CNT_W'(w_byte + 8'd3);
                            n_sum         = r_sum + w_byte;
                            n_byte_count  = CNT_W'(3);
                        end
                    end else begin
                        if (r_byte_count == POS_CMD_HI) begin
                            n_cmd = {w_byte, 8'h00};
                        end else if (r_byte_count == POS_CMD_LO) begin
                            n_cmd = {r_cmd[15:8], w_byte};
                        end else if (r_byte_count < POS_SUM) begin
                            w_wr_en = 1'b1;
                        end

                        if (w_pos_next != r_frame_total) begin
                            n_byte_count = w_pos_next;
                            if (r_byte_count < POS_SUM) begin
                                n_sum = r_sum + w_byte;
                            end
                        end else begin
                            // Last byte: checks in order command, length,
                            // checksum. The command is complete by now.
                            n_byte_count  = '0;
                            n_frame_total = '0;
                            n_idx         = '0;
                            if (r_cmd != SN_CMD) begin
                                n_result = RES_PARAM;
                                n_state  = S_REPLY;
                            end else if (r_length != LEN_GOOD) begin
                                n_result = RES_LENGTH;
                                n_state  = S_REPLY;
                            end else if (r_sum != w_byte) begin
                                n_result = RES_CHECKSUM;
                                n_state  = S_REPLY;
                            end else begin
                                n_await = 1'b1;
                                n_state = S_SER_RD;
                            end
                        end
                    end
                end
            end
            S_REPLY: begin
                if (w_slot_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_kind   = KIND_REPLY;
                    n_m_data   = reply_byte(r_idx[2:0], r_cmd, r_result);
                    n_m_last   = (r_idx[2:0] == REPLY_LAST);
                    n_m_ok     = r_ok_flag;
                    if (r_idx[2:0] == REPLY_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_SER_RD: begin
                // The buffer read of entry r_idx completes at this edge.
                n_state = S_SER_WR;
            end
            S_SER_WR: begin
                if (w_slot_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_kind   = KIND_SERIAL;
                    n_m_data   = r_mem_q;
                    n_m_last   = (r_idx == IDX_W'(SERIAL_BYTES - 1));
                    n_m_ok     = r_ok_flag;
                    if (r_idx == IDX_W'(SERIAL_BYTES - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_SER_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_byte_count  <= '0;
            r_frame_total <= '0;
            r_length      <= '0;
            r_cmd         <= '0;
            r_sum         <= '0;
            r_await       <= 1'b0;
            r_ok_flag     <= 1'b0;
            r_idx         <= '0;
            r_m_tvalid    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_byte_count  <= n_byte_count;
            r_frame_total <= n_frame_total;
            r_length      <= n_length;
            r_cmd         <= n_cmd;
            r_sum         <= n_sum;
            r_await       <= n_await;
            r_ok_flag     <= n_ok_flag;
            r_idx         <= n_idx;
            r_m_tvalid    <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
        r_m_kind <= n_m_kind;
        r_m_ok   <= n_m_ok;
    end

    // Serial byte buffer: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_byte;
        end
        r_mem_q <= r_mem[r_idx[SER_AW-1:0]];
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {7'b0, r_m_ok, r_m_data};
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_kind;

`ifndef ASSERT_OFF
    // Every serial byte but the last leaves during the run of a good frame,
    // which arms the outcome wait.
    a_serial_needs_await: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_SERIAL && !o_m_tlast) |-> r_await)
        else $error("serial byte emitted without an armed outcome wait");

    // Inside a frame body the count stays below the frame total.
    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_count >= CNT_W'(3)) |-> (r_byte_count < r_frame_total))
        else $error("byte count ran past the frame total");

    // The success flag changes only after an accepted outcome word.
    a_flag_by_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_ok_flag) |-> $past(w_accept && w_func == FUNC_REPORT))
        else $error("serial_ok changed without an outcome word");
`endif

endmodule
